// File: src/lsc_pkg.sv
// Shared types and constants of the lookahead stereo compressor.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package lsc_pkg;

   // Field widths of the channels and the configuration registers.
   localparam int SAMPLE_W   = 32;
   localparam int PAIR_W     = 2 * SAMPLE_W;
   localparam int GAIN_W     = 25;
   localparam int COUNT_W    = 21;
   localparam int LEN_W      = 20;
   localparam int THR_W      = 31;
   localparam int LOOK_W     = 11;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;
   localparam int PROD_W     = SAMPLE_W + GAIN_W;
   localparam int FRAC_W     = 24;

   // Output queue depth and the widths that follow from it.
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_AW    = 2;
   localparam int OUTQ_CW    = 3;

   // Gain and counter limits.
   localparam logic [GAIN_W-1:0]  GAIN_ONE  = 25'h100_0000;
   localparam logic [GAIN_W-1:0]  GAIN_MAX  = 25'h1FF_FFFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 21'h1F_FFFF;

   // Item kinds on the input channel.
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_FLUSH  = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_TRIP_LEVEL      = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_GAIN       = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ATTACK_LENGTH   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ATTACK_STEP     = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_LENGTH  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_STEP    = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_LIMIT      = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_LOOK_DISTANCE   = 4'd7;

   // Gain controller modes.
   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_ATTACK = 2'd1,
      MODE_HOLD   = 2'd2
   } mode_type;

   // Configuration register file.
   typedef struct packed {
      logic [THR_W-1:0]  trip_level;
      logic [GAIN_W-1:0] hold_gain;
      logic [LEN_W-1:0]  attack_length;
      logic [GAIN_W-1:0] attack_step;
      logic [LEN_W-1:0]  release_length;
      logic [GAIN_W-1:0] release_step;
      logic [LEN_W-1:0]  hold_limit;
      logic [LOOK_W-1:0] look_distance;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      trip_level:      31'd16384,
      hold_gain:       25'd8388608,
      attack_length:   20'd1764,
      attack_step:     25'd4755,
      release_length:  20'd4410,
      release_step:    25'd1902,
      hold_limit:      20'd4410,
      look_distance:   11'd2000
   };

   // Gain decision for one item, passed from the controller to the scaler.
   typedef struct packed {
      logic              apply;
      logic [GAIN_W-1:0] gain;
   } gain_cmd_type;

endpackage

// File: src/lsc_if.sv
// Channel interfaces of the lookahead stereo compressor: input, result and
// configuration write. Depends on lsc_pkg for the field widths.
`timescale 1ns / 1ps

interface lsc_req_if;
   logic                               valid;
   logic                               ready;
   logic                               action;
   logic signed [lsc_pkg::SAMPLE_W-1:0] left_in;
   logic signed [lsc_pkg::SAMPLE_W-1:0] right_in;

   modport source (output valid, action, left_in, right_in, input ready);
   modport sink   (input valid, action, left_in, right_in, output ready);
endinterface

interface lsc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [lsc_pkg::SAMPLE_W-1:0] left_out;
   logic signed [lsc_pkg::SAMPLE_W-1:0] right_out;

   modport source (output valid, left_out, right_out, input ready);
   modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface lsc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [lsc_pkg::CSR_IDX_W-1:0]     index;
   logic [lsc_pkg::CSR_DATA_W-1:0]    wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// File: src/lookahead_stereo_compressor_core.sv
// Lookahead stereo compressor core: delay line memory, gain controller,
// scaler and result queue. Depends on lsc_pkg and the channel interfaces.
`timescale 1ns / 1ps

// The core accepts one item per clock cycle for as long as results are taken:
// a sample item writes the delay memory, and an item that produces a result
// reads it and steps the gain controller, all in the cycle of acceptance. A
// result travels through a registered memory read and a registered multiply
// stage, with truncation and saturation in front of a four-entry result
// queue, from which it is offered; the input stalls only once that queue and
// the stages in flight hold four results. Sample items produce no result until
// look_distance samples are pending; flush items release one pending sample
// each and produce nothing when none is pending. The delay memory needs no
// clearing after reset. Configuration writes are taken in any cycle and must
// only be made while the core is idle.
module lookahead_stereo_compressor_core #(
   parameter int DELAY_DEPTH = 2048
) (
   input  logic         clock,
   input  logic         reset,
   lsc_req_if.sink      req_bus,
   lsc_rsp_if.source    rsp_bus,
   lsc_csr_if.sink      csr_bus
);
   import lsc_pkg::*;

   localparam int AW = $clog2(DELAY_DEPTH);
   localparam int EW = (AW > LOOK_W) ? AW : LOOK_W;

   cfg_type          cfg_ff, cfg_in;
   logic [AW-1:0]    wp_ff, wp_in;
   logic [AW-1:0]    pending_ff, pending_in;
   logic [PAIR_W-1:0] last_ff, last_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_bypass_ff, s1_bypass_in;
   logic [PAIR_W-1:0] s1_pair_ff, s1_pair_in;
   gain_cmd_type     s1_cmd_ff, s1_cmd_in;

   logic              accept, is_flush, is_sample, produce;
   logic [EW-1:0]     look_ext;
   logic [AW-1:0]     eff;
   logic [AW:0]       rd_wide;
   logic [AW-1:0]     rd_addr;
   logic [PAIR_W-1:0] new_pair, test_pair, mem_rd_pair, s1_in_pair;
   gain_cmd_type      cmd;
   logic              scl_busy, scl_valid;
   logic [PAIR_W-1:0] scl_pair, head_pair;
   logic [OUTQ_CW-1:0] q_fill, in_flight;
   logic              q_not_empty;

   // Configuration writes; values are cut to register width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            REG_TRIP_LEVEL:      cfg_in.trip_level      = csr_bus.wdata[THR_W-1:0];
            REG_HOLD_GAIN:       cfg_in.hold_gain       = csr_bus.wdata[GAIN_W-1:0];
            REG_ATTACK_LENGTH:   cfg_in.attack_length   = csr_bus.wdata[LEN_W-1:0];
            REG_ATTACK_STEP:     cfg_in.attack_step     = csr_bus.wdata[GAIN_W-1:0];
            REG_RELEASE_LENGTH:  cfg_in.release_length  = csr_bus.wdata[LEN_W-1:0];
            REG_RELEASE_STEP:    cfg_in.release_step    = csr_bus.wdata[GAIN_W-1:0];
            REG_HOLD_LIMIT:      cfg_in.hold_limit      = csr_bus.wdata[LEN_W-1:0];
            REG_LOOK_DISTANCE:   cfg_in.look_distance   = csr_bus.wdata[LOOK_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_bus.ready = 1'b1;

   // Item decode.
   assign accept    = req_bus.valid && req_bus.ready;
   assign is_flush  = req_bus.action == ACT_FLUSH;
   assign is_sample = !is_flush;
   assign new_pair  = {req_bus.left_in, req_bus.right_in};

   // Effective delay, limited by the memory depth.
   assign look_ext = EW'(cfg_ff.look_distance);
   assign eff = (look_ext > EW'(DELAY_DEPTH - 1)) ? AW'(DELAY_DEPTH - 1) : AW'(look_ext);

   assign produce = accept && (is_flush ? (pending_ff != '0) : (pending_ff >= eff));

   // The oldest pending sample sits pending_ff entries behind the write pointer.
   assign rd_wide = (wp_ff >= pending_ff) ?
                    ({1'b0, wp_ff} - {1'b0, pending_ff}) :
                    ({1'b0, wp_ff} + (AW+1)'(DELAY_DEPTH) - {1'b0, pending_ff});
   assign rd_addr = rd_wide[AW-1:0];

   // A flush tests against the newest stored sample, kept in a register.
   assign test_pair = is_flush ? last_ff : new_pair;

   // Pointer, pending count and first-stage updates.
   always_comb begin
      wp_in        = wp_ff;
      pending_in   = pending_ff;
      last_in      = last_ff;
      s1_valid_in  = produce;
      // With nothing pending the sample leaves in the cycle it is written,
      // so it is forwarded around the memory.
      s1_bypass_in = pending_ff == '0;
      s1_pair_in   = new_pair;
      s1_cmd_in    = cmd;
      if (accept && is_sample) begin
         wp_in   = (wp_ff == AW'(DELAY_DEPTH - 1)) ? '0 : (wp_ff + 1'b1);
         last_in = new_pair;
         if (pending_ff < eff) begin
            pending_in = pending_ff + 1'b1;
         end
      end
      if (accept && is_flush && (pending_ff != '0)) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= CFG_RESET;
         wp_ff       <= '0;
         pending_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         wp_ff       <= wp_in;
         pending_ff  <= pending_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      s1_bypass_ff <= s1_bypass_in;
      s1_pair_ff   <= s1_pair_in;
      s1_cmd_ff    <= s1_cmd_in;
   end

   // Delay line.
   lsc_delay_mem #(
      .DEPTH (DELAY_DEPTH),
      .AW    (AW)
   ) u_delay_mem (
      .clock   (clock),
      .wr_en   (accept && is_sample),
      .wr_addr (wp_ff),
      .wr_data (new_pair),
      .rd_en   (produce),
      .rd_addr (rd_addr),
      .rd_data (mem_rd_pair)
   );

   // Gain controller steps once per produced result.
   lsc_gain_ctrl u_gain_ctrl (
      .clock      (clock),
      .reset      (reset),
      .step       (produce),
      .test_left  (test_pair[PAIR_W-1:SAMPLE_W]),
      .test_right (test_pair[SAMPLE_W-1:0]),
      .cfg        (cfg_ff),
      .cmd        (cmd)
   );

   assign s1_in_pair = s1_bypass_ff ? s1_pair_ff : mem_rd_pair;

   lsc_scaler u_scaler (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_pair   (s1_in_pair),
      .in_cmd    (s1_cmd_ff),
      .busy      (scl_busy),
      .out_valid (scl_valid),
      .out_pair  (scl_pair)
   );

   lsc_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (scl_valid),
      .push_pair (scl_pair),
      .pop       (rsp_bus.valid && rsp_bus.ready),
      .not_empty (q_not_empty),
      .head_pair (head_pair),
      .fill      (q_fill)
   );

   // Accept only while the queue has room for everything already in flight.
   assign in_flight = q_fill + OUTQ_CW'(s1_valid_ff) + OUTQ_CW'(scl_busy);
   assign req_bus.ready = !reset && (in_flight < OUTQ_CW'(OUTQ_DEPTH));

   assign rsp_bus.valid     = q_not_empty;
   assign rsp_bus.left_out  = head_pair[PAIR_W-1:SAMPLE_W];
   assign rsp_bus.right_out = head_pair[SAMPLE_W-1:0];

endmodule

// File: src/lsc_delay_mem.sv
// Delay line memory: one write port and one read port, registered read data.
// Depends on lsc_pkg for the stereo pair width.
`timescale 1ns / 1ps

module lsc_delay_mem #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [lsc_pkg::PAIR_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [lsc_pkg::PAIR_W-1:0]  rd_data
);
   import lsc_pkg::*;

   logic [PAIR_W-1:0] mem_ff [DEPTH];
   logic [PAIR_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/lsc_gain_ctrl.sv
// Gain controller: idle, attack and hold modes with linear ramps.
// Depends on lsc_pkg for the mode type, the configuration and the gain command.
`timescale 1ns / 1ps

module lsc_gain_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [lsc_pkg::SAMPLE_W-1:0]  test_left,
   input  logic [lsc_pkg::SAMPLE_W-1:0]  test_right,
   input  lsc_pkg::cfg_type              cfg,
   output lsc_pkg::gain_cmd_type         cmd
);
   import lsc_pkg::*;

   mode_type           mode_ff, mode_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;

   logic [SAMPLE_W-1:0] mag_left, mag_right;
   logic                hit;
   logic [COUNT_W-1:0]  count_inc, hold_count;
   logic                hold_done;
   logic [GAIN_W-1:0]   gain_dec, gain_inc;
   logic [GAIN_W:0]     gain_sum;

   // Overshoot test on the newest sample; the magnitude of the most negative
   // value is its unsigned negation.
   assign mag_left  = test_left[SAMPLE_W-1]  ? (~test_left + 1'b1)  : test_left;
   assign mag_right = test_right[SAMPLE_W-1] ? (~test_right + 1'b1) : test_right;
   assign hit = (mag_left > {1'b0, cfg.trip_level}) ||
                (mag_right > {1'b0, cfg.trip_level});

   // Quiet counter of the hold mode, saturating, cleared by an overshoot.
   assign count_inc  = (count_ff < COUNT_MAX) ? (count_ff + 1'b1) : count_ff;
   assign hold_count = hit ? '0 : count_inc;
   assign hold_done  = hold_count > {1'b0, cfg.hold_limit};

   // Ramp steps, saturating at zero and at the gain maximum.
   assign gain_dec = (gain_ff > cfg.attack_step) ? (gain_ff - cfg.attack_step) : '0;
   assign gain_sum = {1'b0, gain_ff} + {1'b0, cfg.release_step};
   assign gain_inc = gain_sum[GAIN_W] ? GAIN_MAX : gain_sum[GAIN_W-1:0];

   // Next mode.
   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         MODE_ATTACK: begin
            if (count_ff == '0) begin
               mode_in = MODE_HOLD;
            end
         end
         MODE_HOLD: begin
            if (hold_done) begin
               mode_in = MODE_IDLE;
            end
         end
         default: begin
            if (hit) begin
               mode_in = MODE_ATTACK;
            end
         end
      endcase
   end

   // Counter, gain and the gain used for this item.
   always_comb begin
      count_in  = count_ff;
      gain_in   = gain_ff;
      cmd.apply = 1'b1;
      cmd.gain  = GAIN_ONE;
      case (mode_ff)
         MODE_ATTACK: begin
            if (count_ff != '0) begin
               gain_in  = gain_dec;
               cmd.gain = gain_dec;
               count_in = count_ff - 1'b1;
            end else begin
               gain_in  = cfg.hold_gain;
               cmd.gain = cfg.hold_gain;
            end
         end
         MODE_HOLD: begin
            count_in = hold_count;
            cmd.gain = cfg.hold_gain;
            if (hold_done) begin
               count_in = {1'b0, cfg.release_length};
               gain_in  = cfg.hold_gain;
            end
         end
         default: begin
            // Idle passes the sample through unless a release ramp runs.
            cmd.apply = 1'b0;
            if (count_ff != '0) begin
               gain_in   = gain_inc;
               cmd.gain  = gain_inc;
               cmd.apply = 1'b1;
               count_in  = count_ff - 1'b1;
            end
            if (hit) begin
               count_in = {1'b0, cfg.attack_length};
               gain_in  = GAIN_ONE;
            end
         end
      endcase
   end

   // State advances once for every item that produces a result.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         count_ff <= '0;
         gain_ff  <= GAIN_ONE;
      end else if (step) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         gain_ff  <= gain_in;
      end
   end

endmodule

// File: src/lsc_scaler.sv
// Two-stage gain scaler: magnitude times Q24 gain, then truncation and
// saturation to 32 bits. Depends on lsc_pkg for widths and the gain command.
`timescale 1ns / 1ps

module lsc_scaler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [lsc_pkg::PAIR_W-1:0]    in_pair,
   input  lsc_pkg::gain_cmd_type         in_cmd,
   output logic                          busy,
   output logic                          out_valid,
   output logic [lsc_pkg::PAIR_W-1:0]    out_pair
);
   import lsc_pkg::*;

   localparam int Q_W = PROD_W - FRAC_W;

   logic                valid_ff;
   logic                apply_ff;
   logic [1:0]          neg_ff;
   logic [PROD_W-1:0]   prod_ff [2];
   logic [SAMPLE_W-1:0] raw_ff [2];

   logic [SAMPLE_W-1:0] lane_in [2];
   logic [SAMPLE_W-1:0] lane_mag [2];
   logic [1:0]          lane_neg;
   logic [PROD_W-1:0]   lane_prod [2];
   logic [Q_W-1:0]      lane_q [2];
   logic [SAMPLE_W-1:0] lane_out [2];

   assign lane_in[0] = in_pair[PAIR_W-1:SAMPLE_W];
   assign lane_in[1] = in_pair[SAMPLE_W-1:0];

   // First stage: sign and magnitude, one multiplier per channel.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         lane_neg[i]  = lane_in[i][SAMPLE_W-1];
         lane_mag[i]  = lane_neg[i] ? (~lane_in[i] + 1'b1) : lane_in[i];
         lane_prod[i] = PROD_W'(lane_mag[i]) * PROD_W'(in_cmd.gain);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      apply_ff <= in_cmd.apply;
      neg_ff   <= lane_neg;
      for (int i = 0; i < 2; i++) begin
         prod_ff[i] <= lane_prod[i];
         raw_ff[i]  <= lane_in[i];
      end
   end

   // Second stage: drop the fraction, saturate, restore the sign.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         lane_q[i] = prod_ff[i][PROD_W-1:FRAC_W];
         if (neg_ff[i]) begin
            // A negative result can reach down to minus two to the 31st.
            if (lane_q[i] > {2'b01, {(Q_W-2){1'b0}}}) begin
               lane_out[i] = {1'b1, {(SAMPLE_W-1){1'b0}}};
            end else begin
               lane_out[i] = ~lane_q[i][SAMPLE_W-1:0] + 1'b1;
            end
         end else begin
            if (lane_q[i] > {2'b00, {(Q_W-2){1'b1}}}) begin
               lane_out[i] = {1'b0, {(SAMPLE_W-1){1'b1}}};
            end else begin
               lane_out[i] = lane_q[i][SAMPLE_W-1:0];
            end
         end
         if (!apply_ff) begin
            lane_out[i] = raw_ff[i];
         end
      end
   end

   assign busy      = valid_ff;
   assign out_valid = valid_ff;
   assign out_pair  = {lane_out[0], lane_out[1]};

endmodule

// File: src/lsc_out_fifo.sv
// Result queue that decouples the pipeline from the output handshake.
// Depends on lsc_pkg for the queue depth and the pair width.
`timescale 1ns / 1ps

module lsc_out_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [lsc_pkg::PAIR_W-1:0]  push_pair,
   input  logic                        pop,
   output logic                        not_empty,
   output logic [lsc_pkg::PAIR_W-1:0]  head_pair,
   output logic [lsc_pkg::OUTQ_CW-1:0] fill
);
   import lsc_pkg::*;

   logic [PAIR_W-1:0]  entry_ff [OUTQ_DEPTH];
   logic [OUTQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUTQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_CW-1:0] fill_ff, fill_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_pair;
      end
   end

   assign not_empty = fill_ff != '0;
   assign head_pair = entry_ff[rd_ptr_ff];
   assign fill      = fill_ff;

endmodule

// File: src/lsc_checker.sv
// Port-level checks of the lookahead stereo compressor core, bound to the core
// module. Depends on lsc_pkg and on the port names of the core.
`timescale 1ns / 1ps

module lsc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lsc_pkg::SAMPLE_W-1:0]  rsp_left_out,
   input logic [lsc_pkg::SAMPLE_W-1:0]  rsp_right_out
);
   import lsc_pkg::*;

   logic [31:0] owed_ff, owed_in;
   logic        in_acc, out_acc;

   assign in_acc  = req_valid && req_ready;
   assign out_acc = rsp_valid && rsp_ready;

   // Items taken minus results delivered.
   always_comb begin
      owed_in = owed_ff;
      if (in_acc && !out_acc) begin
         owed_in = owed_ff + 1'b1;
      end else if (out_acc && !in_acc) begin
         owed_in = owed_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff <= '0;
      end else begin
         owed_ff <= owed_in;
      end
   end

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its value.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_left_out) && $stable(rsp_right_out))
      else $error("result changed while stalled");

   // Every result is caused by an earlier item.
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      out_acc |-> owed_ff != '0)
      else $error("result without a preceding item");

   // The input only stalls when results are waiting at the output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result waiting");

endmodule

bind lookahead_stereo_compressor_core lsc_checker u_lsc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_left_out  (rsp_bus.left_out),
   .rsp_right_out (rsp_bus.right_out)
);

// File: tb/testbench.sv
// Self-checking testbench of the lookahead stereo compressor core.
// Depends on lsc_pkg, the channel interfaces and the core; predicts every result.
`timescale 1ns / 1ps

module testbench;
   import lsc_pkg::*;

   localparam int LINE_DEPTH = 2048;
   localparam int REG_COUNT  = 8;

   typedef struct packed {
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
   } pair_type;

   logic clock;
   logic reset;
   int   fail_count      = 0;
   int   hold_off_cycles = 0;
   bit   sender_gaps_on  = 1'b1;
   bit   rsp_stalls_on   = 1'b1;

   lsc_req_if req_ch ();
   lsc_rsp_if rsp_ch ();
   lsc_csr_if csr_ch ();

   lookahead_stereo_compressor_core #(.DELAY_DEPTH(LINE_DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Predicted copy of the registers and of the compressor state.
   cfg_type            cfg;
   mode_type           ctl_mode;
   logic [COUNT_W-1:0] ctl_countdown;
   logic [GAIN_W-1:0]  ctl_gain;
   pair_type           line_store [LINE_DEPTH];
   int unsigned        line_wr_ptr;
   int unsigned        line_pending;
   pair_type           expected_pairs [$];

   function automatic bit exceeds_threshold(logic [SAMPLE_W-1:0] s);
      logic [SAMPLE_W-1:0] mag;
      mag = s[SAMPLE_W-1] ? (32'd0 - s) : s;
      return mag > {1'b0, cfg.trip_level};
   endfunction

   // Multiply by a Q24 gain, truncate toward zero and saturate to 32 bits.
   function automatic logic [SAMPLE_W-1:0] scale_by_gain(logic [SAMPLE_W-1:0] s,
                                                          logic [GAIN_W-1:0] g);
      logic [SAMPLE_W-1:0] mag;
      logic [63:0]         prod;
      mag  = s[SAMPLE_W-1] ? (32'd0 - s) : s;
      prod = ({32'd0, mag} * {39'd0, g}) >> FRAC_W;
      if (s[SAMPLE_W-1]) begin
         if (prod > 64'h8000_0000) prod = 64'h8000_0000;
         return 32'd0 - prod[31:0];
      end
      if (prod > 64'h7FFF_FFFF) prod = 64'h7FFF_FFFF;
      return prod[31:0];
   endfunction

   // One step of the gain controller: the held pair leaves, the probe pair is tested.
   task automatic gain_step(pair_type held, pair_type probe);
      bit                hit;
      bit                apply;
      logic [GAIN_W-1:0] g;
      logic [GAIN_W:0]   sum;
      pair_type          res;
      hit   = exceeds_threshold(probe.left) || exceeds_threshold(probe.right);
      g     = GAIN_ONE;
      apply = 1'b1;
      case (ctl_mode)
         MODE_ATTACK: begin
            if (ctl_countdown != '0) begin
               ctl_gain = (ctl_gain > cfg.attack_step) ? ctl_gain - cfg.attack_step : '0;
               g = ctl_gain;
               ctl_countdown--;
            end else begin
               ctl_mode = MODE_HOLD;
               ctl_gain = cfg.hold_gain;
               g        = cfg.hold_gain;
            end
         end
         MODE_HOLD: begin
            if (ctl_countdown != COUNT_MAX) ctl_countdown++;
            if (hit) ctl_countdown = '0;
            g = cfg.hold_gain;
            if (ctl_countdown > cfg.hold_limit) begin
               ctl_mode      = MODE_IDLE;
               ctl_countdown = {1'b0, cfg.release_length};
               ctl_gain      = cfg.hold_gain;
            end
         end
         default: begin
            // Idle passes the sample through unless a release ramp is running.
            apply = 1'b0;
            if (ctl_countdown != '0) begin
               sum      = {1'b0, ctl_gain} + {1'b0, cfg.release_step};
               ctl_gain = (sum > {1'b0, GAIN_MAX}) ? GAIN_MAX : sum[GAIN_W-1:0];
               g        = ctl_gain;
               apply    = 1'b1;
               ctl_countdown--;
            end
            if (hit) begin
               ctl_mode      = MODE_ATTACK;
               ctl_countdown = {1'b0, cfg.attack_length};
               ctl_gain      = GAIN_ONE;
            end
         end
      endcase
      res.left  = apply ? scale_by_gain(held.left, g) : held.left;
      res.right = apply ? scale_by_gain(held.right, g) : held.right;
      expected_pairs = {expected_pairs, res};
   endtask

   task automatic predict_item(logic act, logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
      int unsigned eff;
      int unsigned k;
      int unsigned n;
      eff = cfg.look_distance;
      if (eff > LINE_DEPTH - 1) eff = LINE_DEPTH - 1;
      if (act == ACT_SAMPLE) begin
         line_store[line_wr_ptr] = '{left: l, right: r};
         line_wr_ptr = (line_wr_ptr + 1) % LINE_DEPTH;
         if (line_pending < eff) begin
            line_pending++;
         end else begin
            k = (line_wr_ptr + LINE_DEPTH - line_pending - 1) % LINE_DEPTH;
            gain_step(line_store[k], '{left: l, right: r});
         end
      end else if (line_pending != 0) begin
         // A flush releases the oldest pending pair, tested against the newest one.
         k = (line_wr_ptr + LINE_DEPTH - line_pending) % LINE_DEPTH;
         n = (line_wr_ptr + LINE_DEPTH - 1) % LINE_DEPTH;
         gain_step(line_store[k], line_store[n]);
         line_pending--;
      end
   endtask

   task automatic apply_config(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_TRIP_LEVEL:      cfg.trip_level      = data[THR_W-1:0];
         REG_HOLD_GAIN:       cfg.hold_gain       = data[GAIN_W-1:0];
         REG_ATTACK_LENGTH:   cfg.attack_length   = data[LEN_W-1:0];
         REG_ATTACK_STEP:     cfg.attack_step     = data[GAIN_W-1:0];
         REG_RELEASE_LENGTH:  cfg.release_length  = data[LEN_W-1:0];
         REG_RELEASE_STEP:    cfg.release_step    = data[GAIN_W-1:0];
         REG_HOLD_LIMIT:      cfg.hold_limit      = data[LEN_W-1:0];
         REG_LOOK_DISTANCE:   cfg.look_distance   = data[LOOK_W-1:0];
         default: ;
      endcase
   endtask

   // Track every accepted write and item, and check every accepted result.
   always @(posedge clock) begin
      pair_type want;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) apply_config(csr_ch.index, csr_ch.wdata);
         if (req_ch.valid && req_ch.ready)
            predict_item(req_ch.action, req_ch.left_in, req_ch.right_in);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_pairs.size() == 0) begin
               $error("unexpected result item: left_out %0d, right_out %0d",
                      $signed(rsp_ch.left_out), $signed(rsp_ch.right_out));
               fail_count++;
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_ch.left_out !== want.left) begin
                  $error("left_out: expected %0d, actual %0d",
                         $signed(want.left), $signed(rsp_ch.left_out));
                  fail_count++;
               end
               if (rsp_ch.right_out !== want.right) begin
                  $error("right_out: expected %0d, actual %0d",
                         $signed(want.right), $signed(rsp_ch.right_out));
                  fail_count++;
               end
            end
         end
      end
   end

   // Gap length: mostly none or short, now and then long.
   function automatic int pick_gap(int longest);
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(longest / 2, longest);
   endfunction

   // Result receiver: random stalls plus a long hold-off on request.
   initial begin
      int stall;
      stall        = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ch.ready    <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
         end else if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (rsp_stalls_on) stall = pick_gap(60);
         end
      end
   end

   // Offer one item and return at the edge where it is accepted.
   task automatic send_item(logic act, logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
      int gap;
      gap = sender_gaps_on ? pick_gap(40) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.action   <= act;
      req_ch.left_in  <= l;
      req_ch.right_in <= r;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Write one register; bits above its width are sometimes filled with junk.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value, int width);
      logic [CSR_DATA_W-1:0] junk;
      junk = (width < CSR_DATA_W && $urandom_range(0, 3) == 0) ? ($urandom << width) : '0;
      csr_ch.index <= idx;
      csr_ch.wdata <= value | junk;
      csr_ch.valid <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stop offering items and let every expected result come out.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (expected_pairs.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Drain the delay line, with one extra flush that finds nothing pending.
   task automatic flush_all();
      int n;
      wait_for_results();
      n = line_pending + 1;
      repeat (n) send_item(ACT_FLUSH, $urandom, $urandom);
      wait_for_results();
   endtask

   function automatic logic [SAMPLE_W-1:0] quiet_sample(int unsigned thr);
      int unsigned mag;
      mag = ($urandom_range(0, 4) == 0) ? thr : $urandom_range(0, thr);
      return $urandom_range(0, 1) ? 32'd0 - mag : mag;
   endfunction

   function automatic logic [SAMPLE_W-1:0] loud_sample(int unsigned thr);
      int unsigned mag;
      if (thr >= 32'h7FFF_FFFF || $urandom_range(0, 9) == 0) return 32'h8000_0000;
      mag = ($urandom_range(0, 4) == 0) ? thr + 1 : $urandom_range(thr + 1, 32'h7FFF_FFFF);
      return $urandom_range(0, 1) ? 32'd0 - mag : mag;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_count(int unsigned longest);
      int r;
      r = $urandom_range(0, 19);
      if (r < 2) return 0;
      if (r == 2) return 20'hF_FFFF;
      return $urandom_range(1, longest);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_gain_value();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 25'h1FF_FFFF;
         2: return GAIN_ONE;
         3: return $urandom_range(0, 1 << 20);
         default: return $urandom_range(0, 1 << 24);
      endcase
   endfunction

   // Quiet runs, loud bursts, flushes and noise, as in a real program.
   task automatic send_sequence(int unsigned thr, int unsigned hold, int target);
      int sent;
      int len;
      int r;
      sent = 0;
      while (sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            len = $urandom_range(1, (hold + 3 < 24) ? hold + 3 : 24);
            repeat (len) send_item(ACT_SAMPLE, quiet_sample(thr), quiet_sample(thr));
         end else if (r < 75) begin
            len = $urandom_range(1, 3);
            repeat (len) begin
               if ($urandom_range(0, 1))
                  send_item(ACT_SAMPLE, loud_sample(thr),
                            $urandom_range(0, 1) ? loud_sample(thr) : quiet_sample(thr));
               else
                  send_item(ACT_SAMPLE, quiet_sample(thr), loud_sample(thr));
            end
         end else if (r < 87) begin
            len = $urandom_range(1, 3);
            repeat (len) send_item(ACT_FLUSH, $urandom, $urandom);
         end else begin
            len = $urandom_range(1, 4);
            repeat (len) send_item($urandom_range(0, 1), $urandom, $urandom);
         end
         sent += len;
      end
   endtask

   // Reset values: long look distance, extreme samples, then a full flush.
   task automatic test_reset_defaults();
      send_item(ACT_SAMPLE, 32'h7FFF_FFFF, 32'd16384);
      send_item(ACT_SAMPLE, 32'h8000_0000, 32'd16385);
      send_item(ACT_SAMPLE, 32'd0, 32'd0 - 32'd16385);
      flush_all();
   endtask

   // All-ones writes are cut to each register's width; unused indexes do nothing.
   task automatic test_register_masking();
      for (int i = 0; i < REG_COUNT; i++) write_reg(i[CSR_IDX_W-1:0], 32'hFFFF_FFFF, CSR_DATA_W);
      for (int i = REG_COUNT; i < 2 ** CSR_IDX_W; i++) write_reg(i[CSR_IDX_W-1:0], $urandom, 0);
      send_item(ACT_SAMPLE, 32'h8000_0000, 32'h0000_0001);
      send_item(ACT_SAMPLE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(ACT_SAMPLE, 32'h1234_5678, 32'h8000_0000);
      flush_all();
   endtask

   // Walk through attack, hold, release with saturating gain, and plain idle.
   task automatic test_gain_modes();
      logic [SAMPLE_W-1:0] seq [12];
      seq = '{32'h4000_0000, 32'h8000_0000, 32'hC000_0000, 32'h0000_0001,
              32'h4000_0000, 32'hC000_0000, 32'h4000_0000, 32'hFFFF_FFFF,
              32'h4000_0000, 32'h3FFF_FFFF, 32'h4000_0000, 32'h7FFF_FFFF};
      write_reg(REG_TRIP_LEVEL, 32'h4000_0000, THR_W);
      write_reg(REG_HOLD_GAIN, 32'h0080_0000, GAIN_W);
      write_reg(REG_ATTACK_LENGTH, 2, LEN_W);
      write_reg(REG_ATTACK_STEP, 25'h1FF_FFFF, GAIN_W);
      write_reg(REG_RELEASE_LENGTH, 3, LEN_W);
      write_reg(REG_RELEASE_STEP, 25'h1FF_FFFF, GAIN_W);
      write_reg(REG_HOLD_LIMIT, 1, LEN_W);
      write_reg(REG_LOOK_DISTANCE, 1, LOOK_W);
      foreach (seq[i]) send_item(ACT_SAMPLE, seq[i], {seq[i][31], seq[i][31:1]});
      send_item(ACT_FLUSH, 32'd0, 32'd0);
      wait_for_results();
   endtask

   // Random settings per phase, each followed by sequences with random content.
   task automatic test_random_phases();
      int unsigned thr;
      int unsigned hold;
      int unsigned look;
      for (int phase = 0; phase < 12; phase++) begin
         case ($urandom_range(0, 5))
            0: thr = 0;
            1: thr = 32'h7FFF_FFFF;
            2, 3: thr = $urandom_range(0, 4096);
            4: thr = $urandom_range(1 << 20, 1 << 30);
            default: thr = $urandom & 32'h7FFF_FFFF;
         endcase
         hold = pick_count(12);
         if (phase == 5) look = 2047;
         else if ($urandom_range(0, 19) < 14) look = $urandom_range(0, 4);
         else if ($urandom_range(0, 4) != 0) look = $urandom_range(5, 30);
         else look = $urandom_range(31, 100);
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_stalls_on  = ($urandom_range(0, 3) != 0);
         write_reg(REG_TRIP_LEVEL, thr, THR_W);
         write_reg(REG_HOLD_GAIN, pick_gain_value(), GAIN_W);
         write_reg(REG_ATTACK_LENGTH, pick_count(10), LEN_W);
         write_reg(REG_ATTACK_STEP, pick_gain_value(), GAIN_W);
         write_reg(REG_RELEASE_LENGTH, pick_count(16), LEN_W);
         write_reg(REG_RELEASE_STEP, pick_gain_value(), GAIN_W);
         write_reg(REG_HOLD_LIMIT, hold, LEN_W);
         write_reg(REG_LOOK_DISTANCE, look, LOOK_W);
         send_sequence(thr, hold, 80);
         // Pending samples are sometimes kept so that the next phase lowers the delay.
         if (look > 30 || $urandom_range(0, 1)) flush_all();
         else wait_for_results();
      end
   endtask

   // The receiver holds off long enough for the core to fill and stall its input.
   task automatic test_backpressure();
      sender_gaps_on = 1'b0;
      rsp_stalls_on  = 1'b1;
      write_reg(REG_TRIP_LEVEL, 32'h0001_0000, THR_W);
      write_reg(REG_LOOK_DISTANCE, 0, LOOK_W);
      hold_off_cycles <= 300;
      send_sequence(32'h0001_0000, 4, 40);
      flush_all();
   endtask

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.action   = ACT_SAMPLE;
      req_ch.left_in  = '0;
      req_ch.right_in = '0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = REG_TRIP_LEVEL;
      csr_ch.wdata    = '0;
      cfg             = CFG_RESET;
      ctl_mode        = MODE_IDLE;
      ctl_countdown   = '0;
      ctl_gain        = GAIN_ONE;
      line_wr_ptr     = 0;
      line_pending    = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_register_masking();
      test_gain_modes();
      test_random_phases();
      test_backpressure();

      wait_for_results();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("lookahead_stereo_compressor_core: match");
      else
         $display("lookahead_stereo_compressor_core: mismatch");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #8_000_000;
      $display("lookahead_stereo_compressor_core: mismatch");
      $finish;
   end

endmodule

// File: files.f
src/lsc_pkg.sv
src/lsc_if.sv
src/lsc_delay_mem.sv
src/lsc_gain_ctrl.sv
src/lsc_scaler.sv
src/lsc_out_fifo.sv
src/lookahead_stereo_compressor_core.sv
src/lsc_checker.sv
tb/testbench.sv
